// ===== src/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the save/restore table
// Widths, result and status codes, cell command codes and the structs that
// pass between the table cells and the control logic.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int ENTRIES    = 8;
   localparam int COUNT_BITS = 16;
   localparam int KEY_W      = 32;
   localparam int TTL_W      = 32;

   // result action codes
   localparam logic [1:0] ACT_LEAVE = 2'd0;
   localparam logic [1:0] ACT_SET   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // cell update commands
   localparam logic [2:0] OP_NONE     = 3'd0;
   localparam logic [2:0] OP_SAVE     = 3'd1;
   localparam logic [2:0] OP_INC      = 3'd2;
   localparam logic [2:0] OP_DEC      = 3'd3;
   localparam logic [2:0] OP_DEC_FREE = 3'd4;

   // lookup data handed from cell to cell
   typedef struct packed {
      logic                  hit_seen;
      logic                  free_seen;
      logic [COUNT_BITS-1:0] hit_count;
      logic [TTL_W-1:0]      hit_ttl;
   } chain_type;

   // update command broadcast to every cell
   typedef struct packed {
      logic [2:0]       op;
      logic             to_free;
      logic [KEY_W-1:0] key;
      logic [TTL_W-1:0] ttl;
   } cmd_type;

endpackage

// ===== src/srt_cell.sv =====
// ----------------------------------------------------------------------------
// srt_cell: one table slot
// Holds key, reference count and saved TTL of one entry, joins the lookup
// chain and applies the broadcast update when it is the chosen slot.
// ----------------------------------------------------------------------------
module srt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [srt_pkg::KEY_W-1:0] lookup_key,
   input  srt_pkg::chain_type       chain_in,
   output srt_pkg::chain_type       chain_out,
   input  srt_pkg::cmd_type         cmd
);
   import srt_pkg::*;

   logic [KEY_W-1:0]      key_ff, key_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TTL_W-1:0]      ttl_ff, ttl_in;
   logic                  empty;
   logic                  match;
   logic                  hit_here;
   logic                  free_here;
   logic                  selected;

   assign empty     = (key_ff == '0);
   assign match     = (key_ff == lookup_key) && !empty;
   assign hit_here  = match && !chain_in.hit_seen;
   assign free_here = empty && !chain_in.free_seen;

   // first match and first empty slot win
   always_comb begin
      chain_out.hit_seen  = chain_in.hit_seen | match;
      chain_out.free_seen = chain_in.free_seen | empty;
      chain_out.hit_count = hit_here ? count_ff : chain_in.hit_count;
      chain_out.hit_ttl   = hit_here ? ttl_ff : chain_in.hit_ttl;
   end

   assign selected = cmd.to_free ? free_here : hit_here;

   always_comb begin
      key_in   = key_ff;
      count_in = count_ff;
      ttl_in   = ttl_ff;
      if (selected) begin
         unique case (cmd.op)
            OP_SAVE: begin
               key_in   = cmd.key;
               count_in = COUNT_BITS'(1);
               ttl_in   = cmd.ttl;
            end
            OP_INC: begin
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
            OP_DEC: begin
               count_in = count_ff - COUNT_BITS'(1);
            end
            OP_DEC_FREE: begin
               count_in = count_ff - COUNT_BITS'(1);
               key_in   = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         count_ff <= '0;
      end else begin
         key_ff   <= key_in;
         count_ff <= count_in;
      end
   end

   // saved TTL is only read after a save has written it
   always_ff @(posedge clock) begin
      ttl_ff <= ttl_in;
   end

endmodule

// ===== src/refcounted_save_restore_table.sv =====
// ----------------------------------------------------------------------------
// refcounted_save_restore_table: reference-counted TTL save/restore table
// Associative table of mount keys with per-entry count and saved TTL, built
// as a row of slot cells joined by a lookup chain.
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  req     | in        | valid / stall   | mode, mount_key, current_ttl
//  rsp     | out       | valid / stall   | action, ttl_value, status
//  csr     | in        | valid / ready   | data (infinite TTL code)
//
// A transaction first registers the request, then runs the lookup chain
// through all cells, the decision and the cell update.
// The next request is taken as soon as the current one has been resolved.
// A result waiting under rsp_stall holds the table one transaction deep.
// Synchronous reset empties every slot and allows slot reuse; csr is always
// ready.
// ----------------------------------------------------------------------------
module refcounted_save_restore_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [srt_pkg::KEY_W-1:0]        req_mount_key,
   input  logic signed [srt_pkg::TTL_W-1:0] req_current_ttl,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_action,
   output logic signed [srt_pkg::TTL_W-1:0] rsp_ttl_value,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic signed [srt_pkg::TTL_W-1:0] csr_data
);
   import srt_pkg::*;

   logic             busy_ff, busy_in;
   logic             mode_ff;
   logic [KEY_W-1:0] key_ff;
   logic [TTL_W-1:0] ttl_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       action_ff, action_in;
   logic [TTL_W-1:0] ttlv_ff, ttlv_in;
   logic [1:0]       status_ff, status_in;
   logic             reuse_ff, reuse_in;
   logic [TTL_W-1:0] inf_ff;

   logic             accept;
   logic             go;
   logic             clear_reuse;
   logic [2:0]       op;
   logic             to_free;
   chain_type        chain [ENTRIES+1];
   chain_type        found;
   cmd_type          cmd;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy_ff;
   assign go        = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   assign chain[0] = '{hit_seen: 1'b0, free_seen: 1'b0, hit_count: '0, hit_ttl: '0};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      srt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .lookup_key (key_ff),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .cmd        (cmd)
      );
   end

   assign found = chain[ENTRIES];

   always_comb begin
      action_in   = ACT_LEAVE;
      ttlv_in     = '0;
      status_in   = ST_OK;
      op          = OP_NONE;
      to_free     = 1'b0;
      clear_reuse = 1'b0;
      if (!mode_ff) begin
         priority if (key_ff == '0) begin
            action_in = ACT_SET;
            status_in = ST_FULL;
         end else if (found.hit_seen) begin
            if (found.hit_count == '0) begin
               op        = OP_SAVE;
               action_in = ACT_SET;
            end else begin
               op = OP_INC;
            end
         end else if (found.free_seen) begin
            op        = OP_SAVE;
            to_free   = 1'b1;
            action_in = ACT_SET;
         end else begin
            // table full: nothing stored, slots no longer recycled
            action_in   = ACT_SET;
            status_in   = ST_FULL;
            clear_reuse = 1'b1;
         end
      end else begin
         if (key_ff == '0 || !found.hit_seen || found.hit_count == '0) begin
            status_in = ST_NOT_FOUND;
         end else if (found.hit_count == COUNT_BITS'(1)) begin
            op = reuse_ff ? OP_DEC_FREE : OP_DEC;
            if (found.hit_ttl == inf_ff) begin
               action_in = ACT_CLEAR;
            end else begin
               action_in = ACT_SET;
               ttlv_in   = found.hit_ttl;
            end
         end else begin
            op = OP_DEC;
         end
      end
   end

   assign cmd = '{op: go ? op : OP_NONE, to_free: to_free, key: key_ff, ttl: ttl_ff};

   always_comb begin
      busy_in = busy_ff;
      if (go) begin
         busy_in = 1'b0;
      end else if (accept) begin
         busy_in = 1'b1;
      end
   end

   assign rsp_valid_in = go ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign reuse_in     = (go && clear_reuse) ? 1'b0 : reuse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reuse_ff     <= 1'b1;
         inf_ff       <= '1;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         reuse_ff     <= reuse_in;
         if (csr_valid && csr_ready) begin
            inf_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_mount_key;
         ttl_ff  <= req_current_ttl;
      end
      if (go) begin
         action_ff <= action_in;
         ttlv_ff   <= ttlv_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = action_ff;
   assign rsp_ttl_value = ttlv_ff;
   assign rsp_status    = status_ff;

endmodule

// ===== test/ttl_table_checker.sv =====
// ----------------------------------------------------------------------------
// ttl_table_checker: result checker for the save/restore table
// Watches the request, result and csr channels, keeps its own copy of the
// slot table and the infinite TTL code, and works out the TTL order for each
// accepted request. Each accepted result is compared field by field with the
// oldest outstanding order.
// ----------------------------------------------------------------------------
module ttl_table_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_mode,
   input  logic [srt_pkg::KEY_W-1:0]        req_mount_key,
   input  logic signed [srt_pkg::TTL_W-1:0] req_current_ttl,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [1:0]                       rsp_action,
   input  logic signed [srt_pkg::TTL_W-1:0] rsp_ttl_value,
   input  logic [1:0]                       rsp_status,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic signed [srt_pkg::TTL_W-1:0] csr_data,
   output int                               fail_count,
   output int                               pending,
   output int                               results
);
   import srt_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

   typedef struct packed {
      logic [1:0]       action;
      logic [TTL_W-1:0] ttl_value;
      logic [1:0]       status;
   } ttl_order_type;

   logic [KEY_W-1:0]      slot_key   [ENTRIES];
   logic [COUNT_BITS-1:0] slot_count [ENTRIES];
   logic [TTL_W-1:0]      slot_ttl   [ENTRIES];
   logic                  reuse_ok;
   logic [TTL_W-1:0]      ttl_code;
   ttl_order_type         order_q [$];

   // updates the table for one request and returns the TTL order it gives
   function automatic ttl_order_type resolve_request(logic is_restore, logic [KEY_W-1:0] key,
                                                     logic [TTL_W-1:0] ttl);
      ttl_order_type res;
      int hit;
      int spare;
      res.action    = ACT_LEAVE;
      res.ttl_value = '0;
      res.status    = ST_OK;
      hit   = -1;
      spare = -1;
      // descending scan leaves the lowest match / lowest empty slot
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (key != '0 && slot_key[i] == key)
            hit = i;
         if (slot_key[i] == '0)
            spare = i;
      end
      if (!is_restore) begin
         if (key == '0) begin
            res.action = ACT_SET;
            res.status = ST_FULL;
         end else begin
            if (hit < 0 && spare >= 0) begin
               hit = spare;
               slot_key[hit] = key;
            end
            if (hit < 0) begin
               reuse_ok   = 1'b0;
               res.action = ACT_SET;
               res.status = ST_FULL;
            end else if (slot_count[hit] == '0) begin
               slot_ttl[hit]   = ttl;
               slot_count[hit] = COUNT_BITS'(1);
               res.action      = ACT_SET;
            end else if (slot_count[hit] != COUNT_FULL) begin
               slot_count[hit] = slot_count[hit] + 1'b1;
            end
         end
      end else if (hit < 0 || slot_count[hit] == '0) begin
         res.status = ST_NOT_FOUND;
      end else begin
         slot_count[hit] = slot_count[hit] - 1'b1;
         if (slot_count[hit] == '0) begin
            if (slot_ttl[hit] == ttl_code) begin
               res.action = ACT_CLEAR;
            end else begin
               res.action    = ACT_SET;
               res.ttl_value = slot_ttl[hit];
            end
            if (reuse_ok)
               slot_key[hit] = '0;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      ttl_order_type seen;
      ttl_order_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_key[i]   = '0;
            slot_count[i] = '0;
            slot_ttl[i]   = '0;
         end
         reuse_ok   = 1'b1;
         ttl_code   = '1;
         fail_count = 0;
         results    = 0;
         order_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            ttl_code = csr_data;
         if (rsp_valid && !rsp_stall) begin
            seen.action    = rsp_action;
            seen.ttl_value = rsp_ttl_value;
            seen.status    = rsp_status;
            results++;
            if (order_q.size() == 0) begin
               $display("%0t: unexpected result transaction: action %0d ttl %0d status %0d",
                        $time, seen.action, $signed(seen.ttl_value), seen.status);
               fail_count++;
            end else begin
               want = order_q.pop_front();
               if (seen.action !== want.action) begin
                  $display("%0t: action mismatch, expected %0d, got %0d",
                           $time, want.action, seen.action);
                  fail_count++;
               end
               if (seen.ttl_value !== want.ttl_value) begin
                  $display("%0t: ttl_value mismatch, expected %0d, got %0d",
                           $time, $signed(want.ttl_value), $signed(seen.ttl_value));
                  fail_count++;
               end
               if (seen.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, seen.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            order_q.push_back(resolve_request(req_mode, req_mount_key, req_current_ttl));
      end
      pending = order_q.size();
   end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the refcounted save/restore table
// Drives disable and restore requests with random gaps on both channels,
// rewrites the infinite TTL code between phases and leaves all checking to
// ttl_table_checker. Covers empty and full tables and deep reference counts.
// ----------------------------------------------------------------------------
module testbench;
   import srt_pkg::*;

   localparam logic   MODE_DISABLE = 1'b0;
   localparam logic   MODE_RESTORE = 1'b1;
   localparam int     POOL         = 12;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     STALL_LIMIT  = 4000;
   localparam int     DEEP_COUNT   = 40;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_mode = MODE_DISABLE;
   logic [KEY_W-1:0]        req_mount_key = '0;
   logic signed [TTL_W-1:0] req_current_ttl = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_action;
   logic signed [TTL_W-1:0] rsp_ttl_value;
   logic [1:0]              rsp_status;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic signed [TTL_W-1:0] csr_data = '0;

   logic [KEY_W-1:0]        key_pool [POOL];
   logic signed [TTL_W-1:0] ttl_code = '1;
   bit                      calm = 1'b1;
   bit                      hold_req = 1'b0;
   int                      sent = 0;
   int                      restores = 0;
   int                      code_writes = 0;
   int                      idle_cycles = 0;
   int                      fail_count;
   int                      pending;
   int                      results;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   refcounted_save_restore_table uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_mount_key   (req_mount_key),
      .req_current_ttl (req_current_ttl),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_ttl_value   (rsp_ttl_value),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   ttl_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_mount_key   (req_mount_key),
      .req_current_ttl (req_current_ttl),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_action      (rsp_action),
      .rsp_ttl_value   (rsp_ttl_value),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results         (results)
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 9) != 0)
         return $urandom_range(1, 4);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic signed [TTL_W-1:0] pick_ttl();
      case ($urandom_range(0, 9))
         0, 1, 2: return ttl_code;
         3:       return {1'b0, {(TTL_W-1){1'b1}}};
         4:       return {1'b1, {(TTL_W-1){1'b0}}};
         5:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // returns at the edge where the transaction was taken; valid stays high
   task automatic send_request(logic mode, logic [KEY_W-1:0] key, logic signed [TTL_W-1:0] ttl);
      int gap;
      gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_mount_key   <= key;
      req_current_ttl <= ttl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (mode == MODE_RESTORE)
         restores++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_ttl_code(logic signed [TTL_W-1:0] code);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= code;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ttl_code = code;
      code_writes++;
   endtask

   // random traffic over the first pool_size keys; stray disables only once
   // the table may fill for good
   task automatic run_phase(int count, int pool_size, bit strays);
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 48)
            send_request(MODE_DISABLE, key_pool[$urandom_range(0, pool_size - 1)], pick_ttl());
         else if (pick < 90)
            send_request(MODE_RESTORE, key_pool[$urandom_range(0, pool_size - 1)], pick_ttl());
         else if (pick < 95)
            send_request($urandom_range(0, 1) ? MODE_RESTORE : MODE_DISABLE, '0, pick_ttl());
         else
            send_request((strays && $urandom_range(0, 1)) ? MODE_DISABLE : MODE_RESTORE,
                         $urandom, pick_ttl());
      end
   endtask

   initial begin : result_side
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (gap_len()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [KEY_W-1:0] sat_key;
      sat_key = 32'h5A5A_A5A5;
      key_pool[0] = '1;
      key_pool[1] = 32'd1;
      for (int i = 2; i < POOL; i++) begin
         do key_pool[i] = $urandom; while (key_pool[i] == '0);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: lookups, key zero, save/restore at the TTL extremes
      calm = 1'b1;
      send_request(MODE_RESTORE, 32'd5, 32'sd7);
      send_request(MODE_DISABLE, '0, 32'sd7);
      send_request(MODE_RESTORE, '0, 32'sd7);
      send_request(MODE_DISABLE, '1, 32'sh7FFF_FFFF);
      send_request(MODE_DISABLE, '1, 32'sd123);
      send_request(MODE_RESTORE, '1, '0);
      send_request(MODE_RESTORE, '1, '0);
      send_request(MODE_RESTORE, '1, '0);   // slot freed, now unknown
      send_request(MODE_DISABLE, 32'd1, '1);
      send_request(MODE_RESTORE, 32'd1, '0); // saved value is the infinite code
      send_request(MODE_DISABLE, 32'd2, 32'sh8000_0000);
      send_request(MODE_DISABLE, 32'd3, '0);
      send_request(MODE_RESTORE, 32'd2, '0);
      send_request(MODE_RESTORE, 32'd3, '0);
      send_request(MODE_RESTORE, 32'd3, '0);

      // build up a deep count on one key, then all the way back down
      for (int i = 0; i < DEEP_COUNT; i++)
         send_request(MODE_DISABLE, sat_key, 32'sh1234_5678);
      for (int i = 0; i < DEEP_COUNT; i++)
         send_request(MODE_RESTORE, sat_key, '0);
      send_request(MODE_RESTORE, sat_key, '0);

      write_ttl_code(32'sh7FFF_FFFF);
      run_phase(250, 6, 1'b0);

      // overflow the table: reuse is lost from here on
      write_ttl_code(32'sh8000_0000);
      calm = 1'b1;
      for (int i = 0; i < POOL; i++)
         send_request(MODE_DISABLE, key_pool[i], pick_ttl());
      run_phase(250, POOL, 1'b1);

      write_ttl_code('0);
      hold_req = 1'b1;
      calm     = 1'b0;
      run_phase(250, POOL, 1'b1);

      write_ttl_code($urandom);
      run_phase(250, POOL, 1'b1);

      write_ttl_code('1);
      run_phase(250, POOL, 1'b1);

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests (%0d restores), checked %0d results, %0d TTL code writes.",
               sent, restores, results, code_writes);
      $display("Included key zero, a full table, a deep count and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
